@@ rtl/core/deq_pkg.sv @@
// shared types, constants and ring helpers for the double-ended queue
package deq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 3;
  localparam int DATA_W = 32;
  localparam int ST_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_PUSH_BACK,
    OP_POP_BACK,
    OP_LIST
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } front_q_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
  endfunction

endpackage

@@ rtl/core/deq_if.sv @@
// valid/ready channel interfaces for commands and results
interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::CMD_W-1:0]            command;
  logic signed [deq_pkg::DATA_W-1:0]    value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface deq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::DATA_W-1:0]    value_res;
  logic [deq_pkg::ST_W-1:0]             status;
  logic                                 last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink (input valid, input value_res, input status, input last, output ready);
endinterface

@@ rtl/core/deq_ram.sv @@
// generic single-write, single-read ram with registered read data
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/deq_front.sv @@
// command intake: decode, drop unused codes, two-entry command queue
module deq_front (
  input  logic                clk,
  input  logic                rst_n,
  deq_in_if.sink              in_ch,
  input  logic                q_pop,
  output deq_pkg::front_q_t   q_out
);

  deq_pkg::qent_t ent_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  deq_pkg::op_t   op;
  logic           known;
  logic           push;
  logic           pop;

  always_comb begin
    op    = deq_pkg::OP_LIST;
    known = 1'b1;
    unique case (in_ch.command)
      deq_pkg::CMD_PUSH_FRONT: op = deq_pkg::OP_PUSH_FRONT;
      deq_pkg::CMD_POP_FRONT:  op = deq_pkg::OP_POP_FRONT;
      deq_pkg::CMD_PUSH_BACK:  op = deq_pkg::OP_PUSH_BACK;
      deq_pkg::CMD_POP_BACK:   op = deq_pkg::OP_POP_BACK;
      deq_pkg::CMD_LIST:       op = deq_pkg::OP_LIST;
      default:                 known = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known;
  assign pop         = q_pop && (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{op: op, value: in_ch.value};
    end
  end

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.ent   = ent_r[rp_r];

endmodule

@@ rtl/core/deq_back.sv @@
// command execution: ring indices, store access and result register
module deq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  deq_pkg::front_q_t   q_in,
  output logic                q_pop,
  deq_out_if.source           out_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_OUT  = 5'b00100,
    S_LRD  = 5'b01000,
    S_LOUT = 5'b10000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [deq_pkg::IDX_W-1:0]             head_r, head_nxt;
  logic [deq_pkg::IDX_W-1:0]             tail_r, tail_nxt;
  logic [deq_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [deq_pkg::IDX_W-1:0]             walk_r, walk_nxt;
  logic [deq_pkg::CNT_W-1:0]             left_r, left_nxt;
  logic signed [deq_pkg::DATA_W-1:0]     res_value_r, res_value_nxt;
  logic [deq_pkg::ST_W-1:0]              res_status_r, res_status_nxt;
  logic                                  res_last_r, res_last_nxt;

  logic                                  we;
  logic [deq_pkg::IDX_W-1:0]             waddr;
  logic re;
  logic [deq_pkg::IDX_W-1:0]             raddr;
  logic [deq_pkg::DATA_W-1:0]            rdata;
  logic                                  full;
  logic                                  empty;

  deq_ram #(.WIDTH(deq_pkg::DATA_W), .DEPTH(deq_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_in.ent.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full  = (cnt_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (cnt_r == '0);
  assign q_pop = (state_r == S_IDLE) && q_in.valid;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    walk_nxt       = walk_r;
    left_nxt       = left_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    we             = 1'b0;
    waddr          = head_r;
    re             = 1'b0;
    raddr          = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          res_value_nxt  = '0;
          res_status_nxt = deq_pkg::ST_OK;
          res_last_nxt   = 1'b1;
          state_nxt      = S_OUT;
          case (q_in.ent.op)
            deq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = deq_pkg::ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = deq_pkg::ring_prev(head_r);
                head_nxt = deq_pkg::ring_prev(head_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_status_nxt = deq_pkg::ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = tail_r;
                tail_nxt = deq_pkg::ring_next(tail_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = head_r;
                head_nxt  = deq_pkg::ring_next(head_r);
                cnt_nxt   = cnt_r - 1'b1;
                state_nxt = S_RD;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = deq_pkg::ring_prev(tail_r);
                tail_nxt  = deq_pkg::ring_prev(tail_r);
                cnt_nxt   = cnt_r - 1'b1;
                state_nxt = S_RD;
              end
            end
            default: begin
              if (empty) begin
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = head_r;
                walk_nxt  = deq_pkg::ring_next(head_r);
                left_nxt  = cnt_r;
                state_nxt = S_LRD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        res_value_nxt  = rdata;
        res_status_nxt = deq_pkg::ST_OK;
        res_last_nxt   = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_LRD: begin
        res_value_nxt  = rdata;
        res_status_nxt = deq_pkg::ST_OK;
        res_last_nxt   = (left_r == deq_pkg::CNT_W'(1));
        left_nxt       = left_r - 1'b1;
        state_nxt      = S_LOUT;
      end
      S_LOUT: begin
        if (out_ch.ready) begin
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            re        = 1'b1;
            raddr     = walk_r;
            walk_nxt  = deq_pkg::ring_next(walk_r);
            state_nxt = S_LRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    left_r       <= left_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
  end

  assign out_ch.valid     = (state_r == S_OUT) || (state_r == S_LOUT);
  assign out_ch.value_res = res_value_r;
  assign out_ch.status    = res_status_r;
  assign out_ch.last      = res_last_r;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// top level of the bounded double-ended queue of signed 32-bit words
//
// in_ch carries one command per transfer (push front, pop front, push back,
// pop back, list) with a data word used only by pushes; codes 5 to 7 are
// taken and dropped without any result. out_ch gives the results: the
// popped or listed word, a status (ok, empty, full) and last, set on the
// final result of each command.
// a push result is registered straight from the command queue, while a pop
// first waits for the registered store read; execution takes the next
// command only once the current result has left the result register, and
// list issues the store read for each entry only once the previous entry
// has left the result register.
// a two-entry command queue between intake and execution keeps in_ch ready
// while a result waits, until that queue holds two commands.
// reset (rst_n low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared and are never read before written.
// a stalled receiver holds the result register steady until its transfer.
module double_ended_queue (
  input  logic         clk,
  input  logic         rst_n,
  deq_in_if.sink       in_ch,
  deq_out_if.source    out_ch
);

  // decoded commands travelling from intake to execution
  deq_pkg::front_q_t q_cmd;
  logic              q_pop;

  // intake: decode and buffer commands
  deq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_pop (q_pop),
    .q_out (q_cmd)
  );

  // execution: ring store, indices and result register
  deq_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/core/deq_checker.sv @@
// port-level checks for the double-ended queue, bound to the top level
module deq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [deq_pkg::DATA_W-1:0] out_value_res,
  input logic [deq_pkg::ST_W-1:0]          out_status,
  input logic                              out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res)
      && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != deq_pkg::ST_OK) |-> out_value_res == '0)
    else $error("nonzero word with non-ok status");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != deq_pkg::ST_OK) |-> out_last)
    else $error("error status without last");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == deq_pkg::ST_OK) || (out_status == deq_pkg::ST_EMPTY)
      || (out_status == deq_pkg::ST_FULL))
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value_res (out_ch.value_res),
  .out_status    (out_ch.status),
  .out_last      (out_ch.last)
);

@@ dv/double_ended_queue_tb.sv @@
// self-checking testbench for the bounded double-ended queue
module double_ended_queue_tb;
  import deq_pkg::*;

  // unused command codes sit above list; the block drops them silently
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_LIST + 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;

  // percent of cycles in which a side holds off while idling is on
  localparam int IDLE_PCT = 20;
  // worst case is well under this: lists of up to DEPTH entries read one by
  // one, slowed by receiver stalls, for a few hundred commands
  localparam int CYCLE_LIMIT = 200000;
  // extra cycles after the last expected result to catch stray transfers
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] word;
    logic [ST_W-1:0]          status;
    logic                     last;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the deque: ring store, front and back slots, live count
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  logic [IDX_W-1:0]         shadow_head;
  logic [IDX_W-1:0]         shadow_tail;
  int                       shadow_count;

  // results still owed by the block, oldest first
  deq_result_t pending_results [$];
  deq_result_t want;

  bit idle_en;
  int error_count;
  int cycle_count;
  int results_checked;
  int push_count, pop_count, list_count, unused_count;
  int full_refusals, empty_replies;

  function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] idx);
    return IDX_W'((int'(idx) + 1) % DEPTH);
  endfunction

  function automatic logic [IDX_W-1:0] ring_bwd(input logic [IDX_W-1:0] idx);
    return IDX_W'((int'(idx) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic void owe(input logic signed [DATA_W-1:0] word,
                              input logic [ST_W-1:0] status, input logic last);
    pending_results.push_back('{word: word, status: status, last: last});
  endfunction

  // apply one accepted command to the shadow deque and queue what it yields
  function automatic void predict_deque(input logic [CMD_W-1:0] cmd,
                                        input logic signed [DATA_W-1:0] word);
    logic [IDX_W-1:0] slot;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        push_count++;
        if (shadow_count == DEPTH) begin
          // full: refused, nothing moves
          full_refusals++;
          owe('0, ST_FULL, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            shadow_head = ring_bwd(shadow_head);
            shadow_ring[shadow_head] = word;
          end else begin
            shadow_ring[shadow_tail] = word;
            shadow_tail = ring_fwd(shadow_tail);
          end
          shadow_count++;
          owe('0, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        pop_count++;
        if (shadow_count == 0) begin
          empty_replies++;
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            slot = shadow_head;
            shadow_head = ring_fwd(shadow_head);
          end else begin
            shadow_tail = ring_bwd(shadow_tail);
            slot = shadow_tail;
          end
          shadow_count--;
          owe(shadow_ring[slot], ST_OK, 1'b1);
        end
      end
      CMD_LIST: begin
        list_count++;
        if (shadow_count == 0) begin
          empty_replies++;
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          // front to back, last flag only on the back word
          slot = shadow_head;
          for (int n = 0; n < shadow_count; n++) begin
            owe(shadow_ring[slot], ST_OK, n == shadow_count - 1);
            slot = ring_fwd(slot);
          end
        end
      end
      default: begin
        unused_count++;
      end
    endcase
  endfunction

  // sender: entered just after a falling edge, returns just after one;
  // valid stays high between back-to-back commands so it is never lowered
  // and raised within the same step
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [DATA_W-1:0] word);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= CMD_W'($urandom());
      in_ch.value   <= $urandom();
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= word;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    // transfer taken at this edge
    predict_deque(cmd, word);
    @(negedge clk);
  endtask

  // receiver stalls at random, or never while idling is off
  always @(negedge clk) begin
    out_ch.ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker: every transfer on the result side against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing owed: value=%0d status=%0d last=%0b",
                 $time, out_ch.value_res, out_ch.status, out_ch.last);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value_res !== want.word || out_ch.status !== want.status ||
            out_ch.last !== want.last) begin
          error_count++;
          $display("%0t: expected value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
                   $time, want.word, want.status, want.last,
                   out_ch.value_res, out_ch.status, out_ch.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, pending_results.size());
      $display("double_ended_queue: mismatch");
      $finish;
    end
  end

  // pops and list on an empty deque, then the unused codes, which give nothing
  task automatic test_empty_deque();
    send_command(CMD_POP_FRONT, 32'sd7);
    send_command(CMD_POP_BACK, -32'sd7);
    send_command(CMD_LIST, '0);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
      send_command(CMD_W'(c), $urandom());
    end
  endtask

  // extreme words in at both ends, listed, then drained past empty
  task automatic test_extreme_words();
    send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'sh8000_0000);
    send_command(CMD_PUSH_FRONT, '0);
    send_command(CMD_PUSH_BACK, -32'sd1);
    send_command(CMD_PUSH_FRONT, 32'sh5555_5555);
    send_command(CMD_PUSH_BACK, 32'shaaaa_aaaa);
    send_command(CMD_LIST, -32'sd1);
    repeat (3) begin
      send_command(CMD_POP_FRONT, -32'sd1);
      send_command(CMD_POP_BACK, '0);
    end
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_LIST, '0);
  endtask

  // fill to capacity from random ends, bounce off full, list it, drain past empty
  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom());
    end
    send_command(CMD_PUSH_FRONT, $urandom());
    send_command(CMD_PUSH_BACK, $urandom());
    send_command(CMD_LIST, $urandom());
    while (shadow_count > 0) begin
      send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom());
    end
    send_command(CMD_POP_FRONT, $urandom());
    send_command(CMD_POP_BACK, $urandom());
  endtask

  // random traffic that swings between growing and shrinking phases so the
  // deque keeps hitting full and empty and both indices wrap many times
  task automatic test_random_traffic(input int n_cmds);
    bit growing;
    int pick;
    logic [CMD_W-1:0] cmd;
    growing = 1'b1;
    repeat (n_cmds) begin
      if (shadow_count == DEPTH) growing = 1'b0;
      else if (shadow_count == 0) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      end else if (pick < 12) begin
        cmd = CMD_LIST;
      end else if ((pick < 72) == growing) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_command(cmd, $urandom());
    end
  endtask

  // same traffic with both sides streaming, no gaps and no stalls
  task automatic test_back_to_back(input int n_cmds);
    idle_en = 1'b0;
    test_random_traffic(n_cmds);
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    idle_en       = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.value   = '0;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_count  = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_deque();
    test_extreme_words();
    test_fill_and_drain();
    test_random_traffic(140);
    test_back_to_back(60);
    test_random_traffic(40);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d pushes, %0d pops, %0d lists and %0d unused codes",
             push_count, pop_count, list_count, unused_count);
    $display("checked %0d results, including %0d full refusals and %0d empty replies",
             results_checked, full_refusals, empty_replies);
    if (error_count == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
